// ===== src/sveg_pkg.sv =====
// Shared types and constants for the stereo volume envelope gain unit.
package sveg_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int POS_W = 32;
  localparam int VOL_W = 16;
  localparam int SMP_W = 16;
  localparam int NUM_W = POS_W + VOL_W;
  localparam int CNT_W = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_MONO_SOURCE = 1'b1;

  typedef struct packed {
    logic             le;
    logic [POS_W-1:0] pos;
    logic [VOL_W-1:0] lv;
    logic [VOL_W-1:0] rv;
  } lane_t;

  typedef enum logic [1:0] {
    K_PASS,
    K_HOLD,
    K_INTERP
  } kind_t;

endpackage

// ===== src/sveg_lane.sv =====
// One envelope point slot: storage and position compare.
module sveg_lane import sveg_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [3:0]       wr_idx,
  input  logic [POS_W-1:0] wr_pos,
  input  logic [VOL_W-1:0] wr_lv,
  input  logic [VOL_W-1:0] wr_rv,
  input  logic [POS_W-1:0] frame_pos,
  output lane_t            lane
);

  logic [POS_W-1:0] pos_r;
  logic [VOL_W-1:0] lv_r;
  logic [VOL_W-1:0] rv_r;

  always_ff @(posedge clk) begin
    if (wr_en && ({4'b0, wr_idx} == CNT_W'(LANE))) begin
      pos_r <= wr_pos;
      lv_r  <= wr_lv;
      rv_r  <= wr_rv;
    end
  end

  assign lane.le  = (pos_r <= frame_pos);
  assign lane.pos = pos_r;
  assign lane.lv  = lv_r;
  assign lane.rv  = rv_r;

endmodule

// ===== src/sveg_div.sv =====
// Radix-2 divider for the interpolated volume, one quotient bit per cycle.
module sveg_div import sveg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [POS_W-1:0]     den,
  output logic [VOL_W-1:0]     quot,
  output logic                 done
);

  logic [POS_W-1:0] rem_r, rem_nxt;
  logic [VOL_W-1:0] q_r, q_nxt;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [POS_W:0]   trial;

  // quotient fits 16 bits, so the top 32 numerator bits preload the remainder
  always_comb begin
    trial   = {rem_r, q_r[VOL_W-1]};
    rem_nxt = trial[POS_W-1:0];
    q_nxt   = {q_r[VOL_W-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      rem_nxt  = POS_W'(trial - {1'b0, den});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(VOL_W);
      rem_r  <= num[NUM_W-1:VOL_W];
      q_r    <= num[VOL_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r) else $error("divider did not start");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");

endmodule

// ===== src/stereo_volume_envelope_gain_unit.sv =====
// Top level: envelope point lanes, merge, interpolation and sample gain.
//
//  channel | ports          | role
//  in      | in_t*          | load point (tuser 0) or stereo frame (tuser 1)
//  out     | out_t*         | gained stereo frame, one per frame item
//  cfg     | cfg_*          | point_count (0), mono_source (1)
//
// A load is taken in the idle state. A frame passes the select, multiply and
// final states, adding gain outside the points and divider plus gain when interpolated.
// rst_n is synchronous; point slots are not cleared.
// A result waits in the output register; the next item is taken meanwhile,
// and a finished frame stalls only while that register is full.
module stereo_volume_envelope_gain_unit import sveg_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] point_index, [35:4] point_position, [51:36] point_left_volume,
  // [67:52] point_right_volume, [99:68] frame_position,
  // [115:100] left_sample, [131:116] right_sample
  input  logic [135:0] in_tdata,
  // [0] command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] left_out, [31:16] right_out
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_MUL, S_DIVGO, S_DIV, S_GAIN, S_FIN
  } state_t;

  state_t state_r;
  logic [4:0] count_r;
  logic       mono_r;

  logic [POS_W-1:0] fpos_r;
  logic signed [SMP_W-1:0] ls_r, rs_r;
  kind_t kind_r;
  logic [POS_W-1:0] p0_r, p1_r;
  logic [VOL_W-1:0] v0l_r, v1l_r, v0r_r, v1r_r;
  logic [NUM_W-1:0] m0l_r, m1l_r, m0r_r, m1r_r;
  logic [POS_W-1:0] d_r;
  logic [VOL_W-1:0] vl_r, vr_r;
  logic signed [SMP_W+17:0] pl_r, pr_r;
  logic [SMP_W-1:0] ol_r, or_r;
  logic             ov_r;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lane_t lanes [MAX_POINTS];

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_lane
    sveg_lane #(.LANE(g)) u_lane (
      .clk      (clk),
      .wr_en    (in_acc && (in_tuser == CMD_LOAD)),
      .wr_idx   (in_tdata[3:0]),
      .wr_pos   (in_tdata[35:4]),
      .wr_lv    (in_tdata[51:36]),
      .wr_rv    (in_tdata[67:52]),
      .frame_pos(fpos_r),
      .lane     (lanes[g])
    );
  end

  // merge: first in-use lane lying past the frame
  logic [CNT_W-1:0] n_sat;
  logic [MAX_POINTS-1:0] cur_oh, prv_oh, last_oh;
  logic seen;
  logic [POS_W-1:0] c_pos, p_pos;
  logic [VOL_W-1:0] c_lv, c_rv, p_lv, p_rv, h_lv, h_rv;

  always_comb begin
    n_sat = (CNT_W'(count_r) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                   : CNT_W'(count_r);
    seen = 1'b0;
    c_pos = '0; p_pos = '0;
    c_lv = '0; c_rv = '0; p_lv = '0; p_rv = '0; h_lv = '0; h_rv = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      cur_oh[i]  = (CNT_W'(i) < n_sat) && !lanes[i].le && !seen;
      seen       = seen | cur_oh[i];
      last_oh[i] = (CNT_W'(i) == n_sat - CNT_W'(1));
    end
    prv_oh = cur_oh >> 1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (cur_oh[i]) begin
        c_pos = c_pos | lanes[i].pos;
        c_lv  = c_lv  | lanes[i].lv;
        c_rv  = c_rv  | lanes[i].rv;
      end
      if (prv_oh[i]) begin
        p_pos = p_pos | lanes[i].pos;
        p_lv  = p_lv  | lanes[i].lv;
        p_rv  = p_rv  | lanes[i].rv;
      end
      if (last_oh[i]) begin
        h_lv = h_lv | lanes[i].lv;
        h_rv = h_rv | lanes[i].rv;
      end
    end
  end

  logic [POS_W-1:0] dx;
  assign dx = fpos_r - p0_r;

  logic [VOL_W-1:0] ql, qr;
  logic             dl_done, dr_done;

  sveg_div u_div_l (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DIVGO),
    .num(m0l_r + m1l_r), .den(d_r), .quot(ql), .done(dl_done)
  );
  sveg_div u_div_r (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DIVGO),
    .num(m0r_r + m1r_r), .den(d_r), .quot(qr), .done(dr_done)
  );

  logic [17:0] gl, gr;
  always_comb begin
    if (mono_r) begin
      gl = 18'(vl_r) + 18'(vr_r);
      gr = gl;
    end else begin
      gl = {1'b0, vl_r, 1'b0};
      gr = {1'b0, vr_r, 1'b0};
    end
  end

  function automatic logic [SMP_W-1:0] scale(input logic signed [SMP_W+17:0] p);
    logic signed [SMP_W+17:0] t;
    logic signed [SMP_W+1:0]  q;
    t = p + ((p < 0) ? (SMP_W+18)'(65535) : '0);
    q = (SMP_W+2)'(t >>> 16);
    if (q > 32767)       scale = 16'h7fff;
    else if (q < -32768) scale = 16'h8000;
    else                 scale = q[SMP_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      mono_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_POINT_COUNT) count_r <= cfg_data;
        else                              mono_r  <= cfg_data[0];
      end
      if (out_tvalid && out_tready && state_r != S_FIN) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == CMD_FRAME) begin
            fpos_r  <= in_tdata[99:68];
            ls_r    <= in_tdata[115:100];
            rs_r    <= in_tdata[131:116];
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          p0_r  <= p_pos;
          p1_r  <= c_pos;
          v0l_r <= p_lv; v0r_r <= p_rv;
          v1l_r <= c_lv; v1r_r <= c_rv;
          if (n_sat == '0) begin
            kind_r <= K_PASS;
          end else if (!seen) begin
            kind_r <= K_HOLD;
            vl_r <= h_lv; vr_r <= h_rv;
          end else if (cur_oh[0]) begin
            kind_r <= K_HOLD;
            vl_r <= c_lv; vr_r <= c_rv;
          end else begin
            kind_r <= K_INTERP;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          d_r   <= p1_r - p0_r;
          m0l_r <= v0l_r * (p1_r - p0_r - dx);
          m1l_r <= v1l_r * dx;
          m0r_r <= v0r_r * (p1_r - p0_r - dx);
          m1r_r <= v1r_r * dx;
          case (kind_r)
            K_INTERP: state_r <= S_DIVGO;
            K_HOLD:   state_r <= S_GAIN;
            default:  state_r <= S_FIN;
          endcase
        end
        S_DIVGO: state_r <= S_DIV;
        S_DIV: begin
          if (dl_done) begin
            vl_r    <= ql;
            vr_r    <= qr;
            state_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          pl_r    <= ls_r * $signed(gl);
          pr_r    <= rs_r * $signed(gr);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            if (kind_r == K_PASS) begin
              ol_r <= ls_r;
              or_r <= rs_r;
            end else begin
              ol_r <= scale(pl_r);
              or_r <= scale(pr_r);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {or_r, ol_r};

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cur_oh)) else $error("several lanes chosen");
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    dl_done == dr_done) else $error("channel dividers out of step");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVGO |=> state_r == S_DIV && !dl_done)
    else $error("divider result taken too early");

endmodule
